// ===== hw/rtl/scan_disk_scheduler_assert.svh =====
// assertion macros for the scan disk scheduler, used by sds_ctrl
// expects signals named clk and rst in the scope of each use
`ifndef SCAN_DISK_SCHEDULER_ASSERT_SVH
`define SCAN_DISK_SCHEDULER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SDS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define SDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sds_pkg.sv =====
// shared constants for the scan disk scheduler
// no dependencies
package sds_pkg;

  localparam int MAX_REQUESTS  = 64;
  localparam int CYLINDER_BITS = 16;

  // service position field is fixed at six bits
  localparam int POS_W = 6;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISK_CYLINDERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_UP       = 2'd2;

  // configuration reset values
  localparam int   DISK_RESET  = 200;
  localparam int   START_RESET = 0;
  localparam logic SWEEP_RESET = 1'b1;

endpackage

// ===== hw/rtl/sds_req_if.sv =====
// request channel of the scan disk scheduler: valid/ready plus one request
// depends on sds_pkg for the default cylinder width
interface sds_req_if #(
  parameter int CYL_BITS = sds_pkg::CYLINDER_BITS
) ();
  logic                valid;
  logic                ready;
  logic [CYL_BITS-1:0] request_cylinder;
  logic                final_request;

  modport source (output valid, output request_cylinder, output final_request, input ready);
  modport sink   (input valid, input request_cylinder, input final_request, output ready);
endinterface

// ===== hw/rtl/sds_res_if.sv =====
// result channel of the scan disk scheduler: valid/ready plus one served request
// depends on sds_pkg for default widths
interface sds_res_if #(
  parameter int CYL_BITS = sds_pkg::CYLINDER_BITS
) ();
  logic                       valid;
  logic                       ready;
  logic [CYL_BITS-1:0]        served_cylinder;
  logic [sds_pkg::POS_W-1:0]  service_position;
  logic [CYL_BITS:0]          seek_so_far;
  logic [CYL_BITS:0]          total_seek;
  logic                       last_result;

  modport source (output valid, output served_cylinder, output service_position,
                  output seek_so_far, output total_seek, output last_result,
                  input ready);
  modport sink   (input valid, input served_cylinder, input service_position,
                  input seek_so_far, input total_seek, input last_result,
                  output ready);
endinterface

// ===== hw/rtl/scan_disk_scheduler.sv =====
// Scan (elevator) disk scheduler. While idle, requests load one item per
// cycle into a MAX_REQUESTS-deep store with one write and one read port; the
// item marked final_request starts the batch. The block then finds the upper
// edge, clamps requests to the disk, runs the bubble-sort passes, clamps the
// head, finds where the head splits the batch and picks the sweep; it then
// reads, compares and presents each result in turn, with one turn at the
// sweep edge. The sequence is paced by the single read port of the request
// store and the one shared compare/distance unit, which every step of
// clamping, sorting, splitting and seek accumulation goes through. The block
// takes no new request until the last result of the batch is taken.
// depends on sds_pkg, sds_req_if, sds_res_if, sds_store, sds_alu, sds_ctrl
module scan_disk_scheduler #(
  parameter int MAX_REQUESTS  = sds_pkg::MAX_REQUESTS,
  parameter int CYLINDER_BITS = sds_pkg::CYLINDER_BITS,
  localparam int AW = $clog2(MAX_REQUESTS)
) (
  input  logic                          clk,
  input  logic                          rst,
  sds_req_if.sink                       req,
  sds_res_if.source                     res,
  input  logic                          cfg_we,
  input  logic [sds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CYLINDER_BITS:0]        cfg_data
);

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic [CYLINDER_BITS-1:0] mem_wdata, mem_rdata;
  logic [CYLINDER_BITS-1:0] alu_a, alu_b, alu_diff;
  logic                     alu_lt;

  sds_store #(
    .DEPTH  (MAX_REQUESTS),
    .DATA_W (CYLINDER_BITS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sds_alu #(
    .W (CYLINDER_BITS)
  ) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .lt   (alu_lt),
    .diff (alu_diff)
  );

  sds_ctrl #(
    .MAX_REQUESTS  (MAX_REQUESTS),
    .CYLINDER_BITS (CYLINDER_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .in_cyl     (req.request_cylinder),
    .in_final   (req.final_request),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .out_served (res.served_cylinder),
    .out_pos    (res.service_position),
    .out_seek   (res.seek_so_far),
    .out_total  (res.total_seek),
    .out_last   (res.last_result),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .alu_a      (alu_a),
    .alu_b      (alu_b),
    .alu_lt     (alu_lt),
    .alu_diff   (alu_diff)
  );

endmodule

// ===== hw/rtl/sds_store.sv =====
// request store: single write port, single registered read port
// depends on sds_pkg for default sizes
module sds_store #(
  parameter int DEPTH  = sds_pkg::MAX_REQUESTS,
  parameter int DATA_W = sds_pkg::CYLINDER_BITS,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/sds_alu.sv =====
// shared compare and distance unit: a < b and |a - b|
// depends on sds_pkg for the default width
module sds_alu #(
  parameter int W = sds_pkg::CYLINDER_BITS
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         lt,
  output logic [W-1:0] diff
);

  assign lt   = a < b;
  assign diff = lt ? (b - a) : (a - b);

endmodule

// ===== hw/rtl/sds_ctrl.sv =====
// sequencer of the scan disk scheduler: config registers, load, clamp, sort,
// split and sweep over the request store using the shared compare unit
// depends on sds_pkg and scan_disk_scheduler_assert.svh
`include "scan_disk_scheduler_assert.svh"

module sds_ctrl #(
  parameter int MAX_REQUESTS  = sds_pkg::MAX_REQUESTS,
  parameter int CYLINDER_BITS = sds_pkg::CYLINDER_BITS,
  localparam int AW     = $clog2(MAX_REQUESTS),
  localparam int CNT_W  = $clog2(MAX_REQUESTS + 1),
  localparam int CB     = CYLINDER_BITS,
  localparam int SEEK_W = CYLINDER_BITS + 1,
  localparam int ACC_W  = CYLINDER_BITS + 2
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [sds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CB:0]                   cfg_data,
  // request side
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [CB-1:0]                 in_cyl,
  input  logic                          in_final,
  // result side
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [CB-1:0]                 out_served,
  output logic [sds_pkg::POS_W-1:0]     out_pos,
  output logic [SEEK_W-1:0]             out_seek,
  output logic [SEEK_W-1:0]             out_total,
  output logic                          out_last,
  // request store
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [CB-1:0]                 mem_wdata,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [CB-1:0]                 mem_rdata,
  // shared compare unit
  output logic [CB-1:0]                 alu_a,
  output logic [CB-1:0]                 alu_b,
  input  logic                          alu_lt,
  input  logic [CB-1:0]                 alu_diff
);

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_EDGE_CALC = 5'd1;
  localparam logic [4:0] S_SAT_RD    = 5'd2;
  localparam logic [4:0] S_SAT_CMP   = 5'd3;
  localparam logic [4:0] S_PASS_RD0  = 5'd4;
  localparam logic [4:0] S_PASS_LD0  = 5'd5;
  localparam logic [4:0] S_PASS_RD   = 5'd6;
  localparam logic [4:0] S_PASS_CMP  = 5'd7;
  localparam logic [4:0] S_PASS_END  = 5'd8;
  localparam logic [4:0] S_HEAD      = 5'd9;
  localparam logic [4:0] S_SPLIT_RD  = 5'd10;
  localparam logic [4:0] S_SPLIT_CMP = 5'd11;
  localparam logic [4:0] S_SWEEP     = 5'd12;
  localparam logic [4:0] S_EMIT_RD   = 5'd13;
  localparam logic [4:0] S_EMIT_CMP  = 5'd14;
  localparam logic [4:0] S_PRESENT   = 5'd15;
  localparam logic [4:0] S_EDGE      = 5'd16;

  // configuration registers
  logic [CB:0]   disk;
  logic [CB-1:0] start;
  logic          sweep_up;

  // control state
  logic [4:0]       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] split, split_next;
  logic [AW-1:0]    lim, lim_next;
  logic [AW-1:0]    k, k_next;
  logic             second, second_next;
  logic             hold_last, hold_last_next;
  logic [CB-1:0]    head, head_next;
  logic [ACC_W-1:0] acc, acc_next;

  // payload registers
  logic [CB-1:0]    edge_cyl, edge_next;
  logic [CB-1:0]    carry, carry_next;
  logic [CB-1:0]    served_next;
  logic [AW-1:0]    pos_q, pos_next;
  logic [SEEK_W-1:0] seek_next, total_next;
  logic             last_next;

  logic             in_fire, out_fire;
  logic [CNT_W-1:0] last_idx;
  logic             idx_is_last, k_is_last, ascending, side_more;
  logic [ACC_W-1:0] acc_sum;
  logic [CB-1:0]    edge_calc, target;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_PRESENT);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  assign last_idx    = count - CNT_W'(1);
  assign idx_is_last = (idx == last_idx);
  assign k_is_last   = (CNT_W'(k) == last_idx);
  assign acc_sum     = acc + ACC_W'(alu_diff);
  assign ascending   = sweep_up ^ second;
  assign side_more   = ascending ? !idx_is_last : (idx != '0);
  assign target      = sweep_up ? edge_cyl : '0;
  assign mem_raddr   = idx[AW-1:0];
  assign out_pos     = sds_pkg::POS_W'(pos_q);

  // upper edge: size zero acts as one cylinder, oversize clamps to the full range
  always_comb begin
    if (disk[CB]) begin
      edge_calc = '1;
    end else if (disk[CB-1:0] == '0) begin
      edge_calc = '0;
    end else begin
      edge_calc = disk[CB-1:0] - CB'(1);
    end
  end

  // operand selection for the shared unit
  always_comb begin
    alu_a = head;
    alu_b = mem_rdata;
    unique case (state)
      S_SAT_CMP:  begin alu_a = edge_cyl;  alu_b = mem_rdata; end
      S_PASS_CMP: begin alu_a = mem_rdata; alu_b = carry;     end
      S_HEAD:     begin alu_a = edge_cyl;  alu_b = start;     end
      S_EDGE:     begin alu_a = head;      alu_b = target;    end
      default:    begin alu_a = head;      alu_b = mem_rdata; end
    endcase
  end

  // store write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx[AW-1:0];
    mem_wdata = edge_cyl;
    unique case (state)
      S_IDLE: begin
        mem_we    = in_fire && (count != CNT_W'(MAX_REQUESTS));
        mem_waddr = count[AW-1:0];
        mem_wdata = in_cyl;
      end
      S_SAT_CMP: begin
        mem_we    = alu_lt;
        mem_waddr = idx[AW-1:0];
        mem_wdata = edge_cyl;
      end
      S_PASS_CMP: begin
        // smaller value moves down one slot, larger one travels on in carry
        mem_we    = 1'b1;
        mem_waddr = idx[AW-1:0] - AW'(1);
        mem_wdata = alu_lt ? mem_rdata : carry;
      end
      S_PASS_END: begin
        mem_we    = 1'b1;
        mem_waddr = lim;
        mem_wdata = carry;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    split_next     = split;
    lim_next       = lim;
    k_next         = k;
    second_next    = second;
    hold_last_next = hold_last;
    head_next      = head;
    acc_next       = acc;
    edge_next      = edge_cyl;
    carry_next     = carry;
    served_next    = out_served;
    pos_next       = pos_q;
    seek_next      = out_seek;
    total_next     = out_total;
    last_next      = out_last;

    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (count != CNT_W'(MAX_REQUESTS)) begin
            count_next = count + CNT_W'(1);
          end
          if (in_final) begin
            state_next = S_EDGE_CALC;
          end
        end
      end
      S_EDGE_CALC: begin
        edge_next  = edge_calc;
        idx_next   = '0;
        state_next = S_SAT_RD;
      end
      S_SAT_RD: begin
        state_next = S_SAT_CMP;
      end
      S_SAT_CMP: begin
        if (idx_is_last) begin
          lim_next   = last_idx[AW-1:0];
          idx_next   = '0;
          state_next = (count == CNT_W'(1)) ? S_HEAD : S_PASS_RD0;
        end else begin
          idx_next   = idx + CNT_W'(1);
          state_next = S_SAT_RD;
        end
      end
      S_PASS_RD0: begin
        state_next = S_PASS_LD0;
      end
      S_PASS_LD0: begin
        carry_next = mem_rdata;
        idx_next   = CNT_W'(1);
        state_next = S_PASS_RD;
      end
      S_PASS_RD: begin
        state_next = S_PASS_CMP;
      end
      S_PASS_CMP: begin
        if (!alu_lt) begin
          carry_next = mem_rdata;
        end
        if (idx == CNT_W'(lim)) begin
          state_next = S_PASS_END;
        end else begin
          idx_next   = idx + CNT_W'(1);
          state_next = S_PASS_RD;
        end
      end
      S_PASS_END: begin
        idx_next = '0;
        if (lim == AW'(1)) begin
          state_next = S_HEAD;
        end else begin
          lim_next   = lim - AW'(1);
          state_next = S_PASS_RD0;
        end
      end
      S_HEAD: begin
        head_next  = alu_lt ? edge_cyl : start;
        acc_next   = '0;
        k_next     = '0;
        idx_next   = '0;
        state_next = S_SPLIT_RD;
      end
      S_SPLIT_RD: begin
        state_next = S_SPLIT_CMP;
      end
      S_SPLIT_CMP: begin
        // first entry strictly above the head opens the upper side
        if (alu_lt) begin
          split_next = idx;
          state_next = S_SWEEP;
        end else if (idx_is_last) begin
          split_next = count;
          state_next = S_SWEEP;
        end else begin
          idx_next   = idx + CNT_W'(1);
          state_next = S_SPLIT_RD;
        end
      end
      S_SWEEP: begin
        second_next = 1'b0;
        if (sweep_up) begin
          idx_next   = split;
          state_next = (split != count) ? S_EMIT_RD : S_EDGE;
        end else begin
          idx_next   = split - CNT_W'(1);
          state_next = (split != '0) ? S_EMIT_RD : S_EDGE;
        end
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_CMP;
      end
      S_EMIT_CMP: begin
        acc_next    = acc_sum;
        head_next   = mem_rdata;
        served_next = mem_rdata;
        pos_next    = k;
        seek_next   = acc_sum[SEEK_W-1:0];
        last_next   = k_is_last;
        total_next  = (k_is_last && second) ? acc_sum[SEEK_W-1:0] : '0;
        // last item on the first side: edge travel still counts in the total
        if (k_is_last && !second) begin
          hold_last_next = 1'b1;
          state_next     = S_EDGE;
        end else begin
          state_next = S_PRESENT;
        end
      end
      S_PRESENT: begin
        if (out_fire) begin
          k_next = k + AW'(1);
          if (out_last) begin
            count_next = '0;
            state_next = S_IDLE;
          end else if (side_more) begin
            idx_next   = ascending ? (idx + CNT_W'(1)) : (idx - CNT_W'(1));
            state_next = S_EMIT_RD;
          end else begin
            state_next = S_EDGE;
          end
        end
      end
      S_EDGE: begin
        acc_next  = acc_sum;
        head_next = target;
        if (hold_last) begin
          hold_last_next = 1'b0;
          total_next     = acc_sum[SEEK_W-1:0];
          state_next     = S_PRESENT;
        end else begin
          second_next = 1'b1;
          idx_next    = sweep_up ? (split - CNT_W'(1)) : split;
          state_next  = S_EMIT_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      disk     <= (CB + 1)'(sds_pkg::DISK_RESET);
      start    <= CB'(sds_pkg::START_RESET);
      sweep_up <= sds_pkg::SWEEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sds_pkg::CFG_DISK_CYLINDERS: disk     <= cfg_data;
        sds_pkg::CFG_START_HEAD:     start    <= cfg_data[CB-1:0];
        sds_pkg::CFG_SWEEP_UP:       sweep_up <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      split     <= '0;
      lim       <= '0;
      k         <= '0;
      second    <= 1'b0;
      hold_last <= 1'b0;
      head      <= '0;
      acc       <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      idx       <= idx_next;
      split     <= split_next;
      lim       <= lim_next;
      k         <= k_next;
      second    <= second_next;
      hold_last <= hold_last_next;
      head      <= head_next;
      acc       <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    edge_cyl   <= edge_next;
    carry      <= carry_next;
    out_served <= served_next;
    pos_q      <= pos_next;
    out_seek   <= seek_next;
    out_total  <= total_next;
    out_last   <= last_next;
  end

  `SDS_ASSERT_SAME(a_count_bound, 1'b1, count <= CNT_W'(MAX_REQUESTS), "request count past store depth")
  `SDS_ASSERT_NEXT(a_batch_done, out_fire && out_last, (count == '0) && (state == S_IDLE), "batch did not close after last item")
  `SDS_ASSERT_SAME(a_hold_in_edge, hold_last, state == S_EDGE, "held last item outside edge step")
  `SDS_ASSERT_SAME(a_pos_in_batch, state == S_PRESENT, CNT_W'(pos_q) < count, "service position outside batch")
  `SDS_ASSERT_SAME(a_head_on_disk, state == S_PRESENT, head <= edge_cyl, "head beyond upper edge")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// self-checking bench for scan_disk_scheduler: directed and random request batches,
// an in-bench scan scheduler predicts every served request and the final seek total
// depends on sds_pkg, sds_req_if, sds_res_if and the scan_disk_scheduler rtl
module testbench;

  localparam int CB    = sds_pkg::CYLINDER_BITS;
  localparam int MAXR  = sds_pkg::MAX_REQUESTS;
  localparam int POS_W = sds_pkg::POS_W;
  localparam int IDX_W = sds_pkg::CFG_IDX_W;

  typedef struct packed {
    logic [CB-1:0] cyl;
    logic          fin;
  } disk_request_t;

  typedef struct packed {
    logic [CB-1:0]    cyl;
    logic [POS_W-1:0] pos;
    logic [CB:0]      seek;
    logic [CB:0]      total;
    logic             last;
  } service_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CB:0] cfg_data;

  sds_req_if req_ch ();
  sds_res_if res_ch ();

  scan_disk_scheduler i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // scheduler copy: configuration and held batch
  logic [CB:0]   disk_cfg;
  logic [CB-1:0] head_cfg;
  logic          sweep_cfg;
  int            held_cyl [MAXR];
  int            held_count;

  disk_request_t pending_q[$];
  service_t      expected_q[$];
  logic          req_fire;
  logic          idling;
  int            req_gap;
  int            res_gap;
  int            errors;
  int            items_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  function automatic int top_cylinder();
    int size;
    size = int'(disk_cfg);
    if (size == 0) size = 1;
    if (size > (1 << CB)) size = 1 << CB;
    return size - 1;
  endfunction

  // add the request to the held batch; on the final one clamp, sort, split at the head and emit the scan service order
  task automatic schedule_request(disk_request_t r);
    int top, head, acc, n, split, k, i, j, tmp, turn_at;
    int order [MAXR];
    service_t e;
    if (held_count < MAXR) begin
      held_cyl[held_count] = int'(r.cyl);
      held_count++;
    end
    if (!r.fin) return;
    top = top_cylinder();
    n = held_count;
    for (i = 0; i < n; i++)
      if (held_cyl[i] > top) held_cyl[i] = top;
    for (i = 1; i < n; i++) begin
      tmp = held_cyl[i];
      j = i - 1;
      while (j >= 0 && held_cyl[j] > tmp) begin
        held_cyl[j + 1] = held_cyl[j];
        j--;
      end
      held_cyl[j + 1] = tmp;
    end
    head = (int'(head_cfg) > top) ? top : int'(head_cfg);
    split = 0;
    while (split < n && held_cyl[split] <= head) split++;
    k = 0;
    if (sweep_cfg) begin
      for (i = split; i < n; i++) order[k++] = held_cyl[i];
      turn_at = k;
      for (i = split - 1; i >= 0; i--) order[k++] = held_cyl[i];
    end else begin
      for (i = split - 1; i >= 0; i--) order[k++] = held_cyl[i];
      turn_at = k;
      for (i = split; i < n; i++) order[k++] = held_cyl[i];
    end
    acc = 0;
    for (k = 0; k <= n; k++) begin
      // head always runs on to the sweep edge before reversing
      if (k == turn_at) begin
        acc += sweep_cfg ? (top - head) : head;
        head = sweep_cfg ? top : 0;
      end
      if (k < n) begin
        acc += (order[k] > head) ? (order[k] - head) : (head - order[k]);
        head = order[k];
        e.cyl   = CB'(order[k]);
        e.pos   = POS_W'(k);
        e.seek  = (CB + 1)'(acc);
        e.total = '0;
        e.last  = 1'b0;
        if (k == n - 1) begin
          e.last = 1'b1;
        end else begin
          expected_q.push_back(e);
        end
      end
    end
    // total is taken after any edge travel that follows the last item
    e.total = (CB + 1)'(acc);
    expected_q.push_back(e);
    held_count = 0;
  endtask

  // accepted items feed the predictor, accepted results are checked
  always @(posedge clk) begin
    service_t e;
    if (rst) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_ch.valid && req_ch.ready;
      if (req_ch.valid && req_ch.ready)
        schedule_request('{cyl: req_ch.request_cylinder, fin: req_ch.final_request});
      if (res_ch.valid && res_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: served_cylinder %0d", res_ch.served_cylinder);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (res_ch.served_cylinder !== e.cyl) begin
            $error("served_cylinder: expected %0d, got %0d", e.cyl, res_ch.served_cylinder);
            errors++;
          end
          if (res_ch.service_position !== e.pos) begin
            $error("service_position: expected %0d, got %0d", e.pos,
                   res_ch.service_position);
            errors++;
          end
          if (res_ch.seek_so_far !== e.seek) begin
            $error("seek_so_far: expected %0d, got %0d", e.seek, res_ch.seek_so_far);
            errors++;
          end
          if (res_ch.total_seek !== e.total) begin
            $error("total_seek: expected %0d, got %0d", e.total, res_ch.total_seek);
            errors++;
          end
          if (res_ch.last_result !== e.last) begin
            $error("last_result: expected %0d, got %0d", e.last, res_ch.last_result);
            errors++;
          end
        end
      end
    end
  end

  // request driver: holds an item until taken, idles in bursts
  always @(negedge clk) begin
    disk_request_t r;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fire) begin
      if (req_gap > 0) begin
        req_gap--;
        req_ch.valid <= 1'b0;
      end else if (pending_q.size() == 0) begin
        req_ch.valid <= 1'b0;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        req_gap = $urandom_range(0, 7);
        req_ch.valid <= 1'b0;
      end else begin
        r = pending_q.pop_front();
        req_ch.valid            <= 1'b1;
        req_ch.request_cylinder <= r.cyl;
        req_ch.final_request    <= r.fin;
      end
    end
  end

  // result side stalls
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (res_gap > 0) begin
      res_gap--;
      res_ch.ready <= 1'b0;
    end else if (idling && $urandom_range(0, 4) == 0) begin
      res_gap = $urandom_range(0, 7);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= (CB + 1)'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      sds_pkg::CFG_DISK_CYLINDERS: disk_cfg  = (CB + 1)'(value);
      sds_pkg::CFG_START_HEAD:     head_cfg  = value[CB-1:0];
      sds_pkg::CFG_SWEEP_UP:       sweep_cfg = value[0];
      default: ;
    endcase
  endtask

  task automatic add_request(int cyl, logic fin);
    pending_q.push_back('{cyl: cyl[CB-1:0], fin: fin});
    items_sent++;
  endtask

  // wait until the batch is fully served and the block has settled
  task automatic drain();
    while (pending_q.size() != 0 || req_ch.valid || expected_q.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic int pick_cylinder();
    int top;
    top = top_cylinder();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, (1 << CB) - 1);
      1: return $urandom_range(0, top);
      2: return int'(head_cfg);
      default: return $urandom_range(top, (1 << CB) - 1);
    endcase
  endfunction

  task automatic random_config();
    case ($urandom_range(0, 3))
      0: write_reg(sds_pkg::CFG_DISK_CYLINDERS, $urandom_range(1, 300));
      1: write_reg(sds_pkg::CFG_DISK_CYLINDERS, 1 << CB);
      2: write_reg(sds_pkg::CFG_DISK_CYLINDERS, $urandom_range(0, (2 << CB) - 1));
      default: write_reg(sds_pkg::CFG_DISK_CYLINDERS, $urandom_range(1, 1 << CB));
    endcase
    if ($urandom_range(0, 1))
      write_reg(sds_pkg::CFG_START_HEAD, $urandom_range(0, top_cylinder()));
    else
      write_reg(sds_pkg::CFG_START_HEAD, $urandom_range(0, (1 << CB) - 1));
    write_reg(sds_pkg::CFG_SWEEP_UP, $urandom_range(0, 1));
  endtask

  initial begin
    int len, i;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = sds_pkg::CFG_DISK_CYLINDERS;
    cfg_data     = '0;
    req_ch.valid = 1'b0;
    req_ch.request_cylinder = '0;
    req_ch.final_request    = 1'b0;
    res_ch.ready = 1'b0;
    disk_cfg     = (CB + 1)'(sds_pkg::DISK_RESET);
    head_cfg     = CB'(sds_pkg::START_RESET);
    sweep_cfg    = sds_pkg::SWEEP_RESET;
    held_count   = 0;
    req_gap      = 0;
    res_gap      = 0;
    errors       = 0;
    items_sent   = 0;
    idling       = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset configuration, two requests past the disk end
    add_request(10, 1'b0);
    add_request(199, 1'b0);
    add_request(250, 1'b0);
    add_request(0, 1'b0);
    add_request(65535, 1'b1);
    drain();

    // request on the head goes to the lower side, after the edge turn
    write_reg(sds_pkg::CFG_DISK_CYLINDERS, 200);
    write_reg(sds_pkg::CFG_START_HEAD, 50);
    write_reg(sds_pkg::CFG_SWEEP_UP, 1);
    add_request(50, 1'b1);
    drain();

    write_reg(sds_pkg::CFG_SWEEP_UP, 0);
    add_request(50, 1'b0);
    add_request(51, 1'b0);
    add_request(49, 1'b0);
    add_request(0, 1'b0);
    add_request(120, 1'b1);
    drain();

    // downward sweep still travels to cylinder zero with nothing below
    add_request(60, 1'b0);
    add_request(70, 1'b1);
    drain();

    // zero disk size acts as one cylinder, head beyond it
    write_reg(sds_pkg::CFG_DISK_CYLINDERS, 0);
    write_reg(sds_pkg::CFG_START_HEAD, 65535);
    add_request(0, 1'b0);
    add_request(7, 1'b0);
    add_request(65535, 1'b1);
    drain();

    // oversize disk saturates to the full cylinder range
    write_reg(sds_pkg::CFG_DISK_CYLINDERS, (2 << CB) - 1);
    write_reg(sds_pkg::CFG_SWEEP_UP, 1);
    add_request(0, 1'b0);
    add_request(65535, 1'b0);
    add_request(32768, 1'b1);
    drain();

    write_reg(sds_pkg::CFG_START_HEAD, 65534);
    write_reg(sds_pkg::CFG_SWEEP_UP, 0);
    add_request(0, 1'b0);
    add_request(65535, 1'b1);
    drain();

    write_reg(sds_pkg::CFG_DISK_CYLINDERS, 1 << CB);
    write_reg(sds_pkg::CFG_START_HEAD, 32768);
    write_reg(sds_pkg::CFG_SWEEP_UP, 1);
    add_request(0, 1'b0);
    add_request(65535, 1'b1);
    drain();

    // overfull batch: requests past the store depth are dropped
    write_reg(sds_pkg::CFG_DISK_CYLINDERS, 200);
    write_reg(sds_pkg::CFG_START_HEAD, 100);
    for (i = 0; i < MAXR + 6; i++)
      add_request($urandom_range(0, 255), i == MAXR + 5);
    drain();

    while (items_sent < 180) begin
      idling = (items_sent < 150) ? ($urandom_range(0, 3) != 0) : 1'b0;
      if ($urandom_range(0, 2) == 0) random_config();
      len = ($urandom_range(0, 14) == 0) ? $urandom_range(40, MAXR) : $urandom_range(1, 10);
      for (i = 0; i < len; i++)
        add_request(pick_cylinder(), i == len - 1);
      drain();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sds_pkg.sv
hw/rtl/sds_req_if.sv
hw/rtl/sds_res_if.sv
hw/rtl/sds_store.sv
hw/rtl/sds_alu.sv
hw/rtl/sds_ctrl.sv
hw/rtl/scan_disk_scheduler.sv
tb/sv/testbench.sv
